// File: sv/mnft_pkg.sv
// Shared types, constants and decode helpers for the MIDI note filter/tracker.
package mnft_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned RING_DEPTH_DEF = 32;
    localparam int unsigned WINDOW_MS_DEF  = 60000;
    localparam int unsigned UPDATE_MS_DEF  = 1000;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic REG_CHANNEL_FILTER = 1'b0;
    localparam logic REG_TRANSPOSE      = 1'b1;

    // Status nibble codes
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;
    localparam logic [3:0] KIND_PROG     = 4'hC;
    localparam logic [3:0] KIND_PRESS    = 4'hD;
    localparam logic [3:0] KIND_SYSTEM   = 4'hF;

    // System status codes with their own lengths
    localparam logic [7:0] SYS_EX_START  = 8'hF0;
    localparam logic [7:0] SYS_QFRAME    = 8'hF1;
    localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
    localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;
    localparam logic [7:0] SYS_UNDEF_F4  = 8'hF4;
    localparam logic [7:0] SYS_UNDEF_F5  = 8'hF5;
    localparam logic [7:0] SYS_EX_END    = 8'hF7;

    localparam logic [6:0] CC_SUSTAIN    = 7'd64;
    localparam logic [6:0] SUSTAIN_ON    = 7'd64;
    localparam logic [6:0] NOTE_MAX      = 7'd127;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;        // latch the input word
        logic exec;        // evaluate the latched word
        logic scan_start;  // open a ring recount
        logic scan_step;   // one ring entry per cycle
        logic scan_commit; // store the recount result
        logic out_load;    // load the output word
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic tick_due;    // latched word is a tick past the update interval
        logic scan_last;   // no more ring reads to issue
    } t_dp_sts;

    // Bytes a status needs; zero means no fixed length
    function automatic logic [1:0] f_expected_length(input logic [7:0] st);
        logic [1:0] need;
        need = 2'd3;
        unique case (st[7:4]) inside
            KIND_PROG, KIND_PRESS: need = 2'd2;
            KIND_SYSTEM: begin
                unique case (st) inside
                    SYS_QFRAME, SYS_SONG_SEL: need = 2'd2;
                    SYS_SONG_POS: need = 2'd3;
                    SYS_EX_START, SYS_UNDEF_F4, SYS_UNDEF_F5, SYS_EX_END: need = 2'd0;
                    default: need = 2'd1;
                endcase
            end
            default: need = 2'd3;
        endcase
        return need;
    endfunction

endpackage

// File: sv/midi_note_filter_tracker.sv
// Top level: MIDI note filter and tracker, controller plus datapath.
//
//  channel | handshake                | word
//  --------+--------------------------+-----------------------------------------
//  input   | i_in_valid / o_in_stall  | action, time, status, data bytes, length
//  output  | o_out_valid / i_out_stall| accepted, note, held, last, sustain, rates
//  config  | psel/penable/pwrite      | channel filter at 0, transpose at 4
//
// A message or a tick that is not due goes from accept through the execute and done states to the next accept.
// A due tick walks the stamp ring in the scan state, one entry per cycle through its
// single read port, between the execute and done states.
// Synchronous active-low reset clears all note state and the ring valid bits at once.
// A stalled output word holds; the next word waits in the controller until it drains.
module midi_note_filter_tracker #(
    parameter int unsigned RING_DEPTH = mnft_pkg::RING_DEPTH_DEF,
    parameter int unsigned WINDOW_MS  = mnft_pkg::WINDOW_MS_DEF,
    parameter int unsigned UPDATE_MS  = mnft_pkg::UPDATE_MS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mnft_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_action,
    input  logic [31:0]                     i_time_ms,
    input  logic [7:0]                      i_status_byte,
    input  logic [6:0]                      i_data_one,
    input  logic [6:0]                      i_data_two,
    input  logic [1:0]                      i_msg_length,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_accepted,
    output logic [6:0]                      o_out_note,
    output logic [7:0]                      o_held_count,
    output logic [6:0]                      o_last_note,
    output logic [6:0]                      o_last_velocity,
    output logic                            o_sustain_down,
    output logic [31:0]                     o_note_events,
    output logic [5:0]                      o_notes_per_minute
);
    import mnft_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mnft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mnft_dp #(
        .RING_DEPTH (RING_DEPTH),
        .WINDOW_MS  (WINDOW_MS),
        .UPDATE_MS  (UPDATE_MS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_action           (i_action),
        .i_time_ms          (i_time_ms),
        .i_status_byte      (i_status_byte),
        .i_data_one         (i_data_one),
        .i_data_two         (i_data_two),
        .i_msg_length       (i_msg_length),
        .o_accepted         (o_accepted),
        .o_out_note         (o_out_note),
        .o_held_count       (o_held_count),
        .o_last_note        (o_last_note),
        .o_last_velocity    (o_last_velocity),
        .o_sustain_down     (o_sustain_down),
        .o_note_events      (o_note_events),
        .o_notes_per_minute (o_notes_per_minute)
    );

endmodule

// File: sv/mnft_ctrl.sv
// Controller: sequences accept, evaluate, ring recount and output load.
module mnft_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  mnft_pkg::t_dp_sts  i_sts,
    output mnft_pkg::t_dp_cmd  o_cmd
);
    import mnft_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   load_ok;

    // output register may be refilled when empty or being drained
    assign load_ok = !r_out_vld || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = i_sts.tick_due ? S_SCAN : S_DONE;
            S_SCAN: if (i_sts.scan_last) n_state = S_DONE;
            S_DONE: if (load_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.take = i_in_valid;
            S_EXEC: begin
                o_cmd.exec       = 1'b1;
                o_cmd.scan_start = i_sts.tick_due;
            end
            S_SCAN: begin
                o_cmd.scan_step   = 1'b1;
                o_cmd.scan_commit = i_sts.scan_last;
            end
            S_DONE: o_cmd.out_load = load_ok;
            default: o_cmd = '0;
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// File: sv/mnft_dp.sv
// Datapath: filter, transpose, note state, stamp ring and recount counter.
module mnft_dp #(
    parameter int unsigned RING_DEPTH = mnft_pkg::RING_DEPTH_DEF,
    parameter int unsigned WINDOW_MS  = mnft_pkg::WINDOW_MS_DEF,
    parameter int unsigned UPDATE_MS  = mnft_pkg::UPDATE_MS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mnft_pkg::t_dp_cmd               i_cmd,
    output mnft_pkg::t_dp_sts               o_sts,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mnft_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input word
    input  logic                            i_action,
    input  logic [31:0]                     i_time_ms,
    input  logic [7:0]                      i_status_byte,
    input  logic [6:0]                      i_data_one,
    input  logic [6:0]                      i_data_two,
    input  logic [1:0]                      i_msg_length,
    // output word
    output logic                            o_accepted,
    output logic [6:0]                      o_out_note,
    output logic [7:0]                      o_held_count,
    output logic [6:0]                      o_last_note,
    output logic [6:0]                      o_last_velocity,
    output logic                            o_sustain_down,
    output logic [31:0]                     o_note_events,
    output logic [5:0]                      o_notes_per_minute
);
    import mnft_pkg::*;

    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned IW = $clog2(RING_DEPTH + 1);
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);

    // configuration registers
    logic [4:0] r_chan_filter;
    logic [7:0] r_transpose;

    // latched input word
    logic        r_action;
    logic [31:0] r_now;
    logic [7:0]  r_status;
    logic [6:0]  r_d1;
    logic [6:0]  r_d2;
    logic [1:0]  r_len;

    // tracked note state
    logic [127:0]  r_held;
    logic [7:0]    r_held_total;
    logic [6:0]    r_latest_note;
    logic [6:0]    r_latest_vel;
    logic [31:0]   r_events;
    logic          r_sustain;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_rate;
    logic [31:0]   r_last_upd;

    // per-item result
    logic       r_res_ok;
    logic [6:0] r_res_note;

    // stamp ring
    logic [31:0]           r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_ring_vld;
    logic [31:0]           r_rd_stamp;
    logic                  r_rd_live;
    logic [IW-1:0]         r_idx;
    logic [CW-1:0]         r_cnt;

    // message decode
    logic [1:0]        need;
    logic [3:0]        kind;
    logic [4:0]        chan;
    logic              pass;
    logic              is_note;
    logic              msg_ok;
    logic              note_on;
    logic              note_off_held;
    logic signed [8:0] shifted;
    logic [6:0]        note;
    logic              sustain_wr;
    logic              cfg_wr;

    // ring recount
    logic          hit;
    logic [CW-1:0] cnt_sum;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          ring_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_filter <= '0;
            r_transpose   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_CHANNEL_FILTER: r_chan_filter <= pwdata[4:0];
                REG_TRANSPOSE:      r_transpose   <= pwdata[7:0];
                default:            r_transpose   <= r_transpose;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CHANNEL_FILTER: prdata = {27'd0, r_chan_filter};
            REG_TRANSPOSE:      prdata = {24'd0, r_transpose};
            default:            prdata = '0;
        endcase
    end

    // input word latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_action <= i_action;
            r_now    <= i_time_ms;
            r_status <= i_status_byte;
            r_d1     <= i_data_one;
            r_d2     <= i_data_two;
            r_len    <= i_msg_length;
        end
    end

    // filter and classify the message
    always_comb begin
        need    = f_expected_length(r_status);
        kind    = r_status[7:4];
        chan    = {1'b0, r_status[3:0]} + 5'd1;
        pass    = (r_len != 2'd0) && r_status[7] && (need != 2'd0) && (r_len >= need)
                  && ((r_chan_filter == 5'd0) || (chan == r_chan_filter));
        is_note = (kind == KIND_NOTE_ON) || (kind == KIND_NOTE_OFF);
        msg_ok  = pass && !(is_note && (r_len != 2'd3));
    end

    // transpose with clamp to 0..127
    always_comb begin
        shifted = $signed({2'b00, r_d1}) + $signed({r_transpose[7], r_transpose});
        if (shifted < 0) begin
            note = 7'd0;
        end else if (shifted > $signed({2'b00, NOTE_MAX})) begin
            note = NOTE_MAX;
        end else begin
            note = shifted[6:0];
        end
    end

    always_comb begin
        note_on       = !r_action && msg_ok && is_note
                        && (kind == KIND_NOTE_ON) && (r_d2 != 7'd0);
        note_off_held = !r_action && msg_ok && is_note && !note_on && r_held[note];
        sustain_wr    = !r_action && msg_ok && (kind == KIND_CTRL)
                        && (r_len == 2'd3) && (r_d1 == CC_SUSTAIN);
        ring_wr       = i_cmd.exec && note_on;
    end

    // tick decision
    assign o_sts.tick_due = r_action && ((r_now - r_last_upd) > 32'(UPDATE_MS));

    // note state and per-item result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= '0;
            r_held_total  <= '0;
            r_latest_note <= '0;
            r_latest_vel  <= '0;
            r_events      <= '0;
            r_sustain     <= 1'b0;
            r_head        <= '0;
        end else if (i_cmd.exec) begin
            if (note_on) begin
                if (!r_held[note]) begin
                    r_held[note] <= 1'b1;
                    r_held_total <= r_held_total + 8'd1;
                end
                r_latest_note <= note;
                r_latest_vel  <= r_d2;
                r_events      <= r_events + 32'd1;
                r_head        <= (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end else if (note_off_held) begin
                r_held[note] <= 1'b0;
                if (r_held_total != 8'd0) begin
                    r_held_total <= r_held_total - 8'd1;
                end
            end
            if (sustain_wr) begin
                r_sustain <= (r_d2 >= SUSTAIN_ON);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_ok   <= !r_action && msg_ok;
            if (r_action) begin
                r_res_note <= 7'd0;
            end else if (msg_ok && is_note) begin
                r_res_note <= note;
            end else begin
                r_res_note <= r_d1;
            end
        end
    end

    // last ring read issued
    assign o_sts.scan_last = (r_idx == IW'(RING_DEPTH));

    // ring read side: one entry per cycle
    always_comb begin
        hit       = r_rd_live && (r_rd_stamp != 32'd0)
                    && ((r_now - r_rd_stamp) < 32'(WINDOW_MS));
        cnt_sum   = r_cnt + CW'(hit);
        rd_en     = i_cmd.scan_start || (i_cmd.scan_step && !o_sts.scan_last);
        rd_addr   = i_cmd.scan_start ? '0 : r_idx[AW-1:0];
    end

    // stamp memory
    always_ff @(posedge i_clk) begin
        if (ring_wr) begin
            r_ring[r_head] <= r_now;
        end
        if (rd_en) begin
            r_rd_stamp <= r_ring[rd_addr];
        end
    end

    // entry valid bits stand in for the cleared ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_rd_live  <= 1'b0;
        end else begin
            if (ring_wr) begin
                r_ring_vld[r_head] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_live <= r_ring_vld[rd_addr];
            end
        end
    end

    // recount walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_cnt      <= '0;
            r_rate     <= '0;
            r_last_upd <= '0;
        end else begin
            if (i_cmd.scan_start) begin
                r_idx <= IW'(1);
                r_cnt <= '0;
            end else if (i_cmd.scan_step) begin
                r_cnt <= cnt_sum;
                if (!o_sts.scan_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.scan_commit) begin
                r_rate     <= cnt_sum;
                r_last_upd <= r_now;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_accepted         <= r_res_ok;
            o_out_note         <= r_res_note;
            o_held_count       <= r_held_total;
            o_last_note        <= r_latest_note;
            o_last_velocity    <= r_latest_vel;
            o_sustain_down     <= r_sustain;
            o_note_events      <= r_events;
            o_notes_per_minute <= 6'(r_rate);
        end
    end

endmodule

// File: test/tb_midi_note_filter_tracker.sv
// Self-checking testbench for the MIDI note filter and tracker: directed and random words.
`timescale 1ns / 100ps

module tb_midi_note_filter_tracker;
    import mnft_pkg::*;

    // Item kinds and status codes not named in the package
    localparam logic       ACT_MESSAGE = 1'b0;
    localparam logic       ACT_TICK    = 1'b1;
    localparam logic [3:0] KIND_POLY   = 4'hA;
    localparam logic [3:0] KIND_BEND   = 4'hE;
    localparam logic [7:0] SYS_TUNE    = 8'hF6;
    localparam logic [7:0] SYS_CLOCK   = 8'hF8;
    localparam logic [7:0] SYS_RESET   = 8'hFF;

    // Register addresses, one 32-bit slot per register
    localparam logic [CFG_ADDR_W-1:0] CHAN_FILTER_ADDR = {REG_CHANNEL_FILTER, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] TRANSPOSE_ADDR   = {REG_TRANSPOSE, 2'b00};

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = RING_DEPTH_DEF + 8;
    localparam int PHASE_WORDS  = 270;
    localparam int PHASES       = 7;
    localparam int REPORT_CAP   = 40;

    typedef struct packed {
        logic        action;
        logic [31:0] time_ms;
        logic [7:0]  status;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [1:0]  length;
    } midi_word_t;

    typedef struct packed {
        logic        accepted;
        logic [6:0]  out_note;
        logic [7:0]  held_count;
        logic [6:0]  last_note;
        logic [6:0]  last_velocity;
        logic        sustain_down;
        logic [31:0] note_events;
        logic [5:0]  notes_per_minute;
    } tracker_result_t;

    // Mirror of the tracker state; predicts each result word and checks the block's output
    class note_state_mirror;
        logic [4:0]        chan_filter;
        logic signed [7:0] transpose;
        bit                held [128];
        int                held_total;
        logic [6:0]        latest_note;
        logic [6:0]        latest_velocity;
        logic [31:0]       event_total;
        bit                sustain;
        logic [31:0]       stamps [RING_DEPTH_DEF];
        int                head;
        int                rate;
        logic [31:0]       last_update;
        tracker_result_t   expected_results [$];
        int                mismatches;
        int                words;
        int                ticks;
        int                accepts;
        int                checked;
        int                peak_held;
        int                peak_rate;

        function new();
            chan_filter     = '0;
            transpose       = '0;
            held_total      = 0;
            latest_note     = '0;
            latest_velocity = '0;
            event_total     = '0;
            sustain         = 1'b0;
            head            = 0;
            rate            = 0;
            last_update     = '0;
            mismatches      = 0;
            words           = 0;
            ticks           = 0;
            accepts         = 0;
            checked         = 0;
            peak_held       = 0;
            peak_rate       = 0;
            foreach (held[i]) held[i] = 1'b0;
            foreach (stamps[i]) stamps[i] = '0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Bytes a status byte needs; zero means no fixed length
        function logic [1:0] bytes_needed(logic [7:0] st);
            if (st[7:4] == KIND_PROG || st[7:4] == KIND_PRESS) return 2'd2;
            if (st[7:4] != KIND_SYSTEM) return 2'd3;
            case (st)
                SYS_QFRAME, SYS_SONG_SEL: return 2'd2;
                SYS_SONG_POS: return 2'd3;
                SYS_EX_START, SYS_UNDEF_F4, SYS_UNDEF_F5, SYS_EX_END: return 2'd0;
                default: return 2'd1;
            endcase
        endfunction

        // Count non-empty stamps inside the rate window
        function void recount(logic [31:0] now);
            logic [31:0] age;
            rate = 0;
            foreach (stamps[i]) begin
                age = now - stamps[i];
                if (stamps[i] != '0 && age < WINDOW_MS_DEF) rate++;
            end
        endfunction

        // Accepted input word: update the mirror and queue the expected result
        function void take_word(midi_word_t w);
            tracker_result_t r;
            logic [31:0]     since;
            logic [1:0]      need;
            logic [4:0]      chan;
            logic [3:0]      kind;
            int              shifted;
            logic [6:0]      note;
            r = '0;
            words++;
            kind = w.status[7:4];
            if (w.action == ACT_TICK) begin
                ticks++;
                since = w.time_ms - last_update;
                if (since > UPDATE_MS_DEF) begin
                    recount(w.time_ms);
                    last_update = w.time_ms;
                end
            end else begin
                r.out_note = w.data_one;
                need = bytes_needed(w.status);
                chan = {1'b0, w.status[3:0]} + 5'd1;
                if (w.status[7] && w.length != 2'd0 && need != 2'd0 && w.length >= need
                        && (chan_filter == '0 || chan == chan_filter)) begin
                    r.accepted = 1'b1;
                    accepts++;
                    if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
                        shifted = int'(w.data_one) + int'(transpose);
                        if (shifted < 0) shifted = 0;
                        else if (shifted > int'(NOTE_MAX)) shifted = int'(NOTE_MAX);
                        note = 7'(shifted);
                        r.out_note = note;
                        if (kind == KIND_NOTE_ON && w.data_two != '0) begin
                            if (!held[note]) begin
                                held[note] = 1'b1;
                                held_total++;
                            end
                            latest_note     = note;
                            latest_velocity = w.data_two;
                            event_total     = event_total + 32'd1;
                            stamps[head]    = w.time_ms;
                            head            = (head + 1) % RING_DEPTH_DEF;
                        end else if (held[note]) begin
                            held[note] = 1'b0;
                            held_total--;
                        end
                    end else if (kind == KIND_CTRL && w.data_one == CC_SUSTAIN) begin
                        sustain = (w.data_two >= SUSTAIN_ON);
                    end
                end
            end
            r.held_count       = 8'(held_total);
            r.last_note        = latest_note;
            r.last_velocity    = latest_velocity;
            r.sustain_down     = sustain;
            r.note_events      = event_total;
            r.notes_per_minute = 6'(rate);
            if (held_total > peak_held) peak_held = held_total;
            if (rate > peak_rate) peak_rate = rate;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            if (mismatches < REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                          checked, name, got, want));
        endtask

        // Output word from the block against the oldest prediction
        task match_result(tracker_result_t got);
            tracker_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result word arrived with nothing expected");
                return;
            end
            want = expected_results.pop_front();
            compare_field("accepted", got.accepted, want.accepted);
            compare_field("out_note", got.out_note, want.out_note);
            compare_field("held_count", got.held_count, want.held_count);
            compare_field("last_note", got.last_note, want.last_note);
            compare_field("last_velocity", got.last_velocity, want.last_velocity);
            compare_field("sustain_down", got.sustain_down, want.sustain_down);
            compare_field("note_events", got.note_events, want.note_events);
            compare_field("notes_per_minute", got.notes_per_minute, want.notes_per_minute);
            checked++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_action;
    logic [31:0]           i_time_ms;
    logic [7:0]            i_status_byte;
    logic [6:0]            i_data_one;
    logic [6:0]            i_data_two;
    logic [1:0]            i_msg_length;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_accepted;
    logic [6:0]            o_out_note;
    logic [7:0]            o_held_count;
    logic [6:0]            o_last_note;
    logic [6:0]            o_last_velocity;
    logic                  o_sustain_down;
    logic [31:0]           o_note_events;
    logic [5:0]            o_notes_per_minute;

    note_state_mirror book = new();

    int          cycle_count  = 0;
    int          quiet_words  = 0;
    int          stall_run    = 0;
    logic        stall_level  = 1'b0;
    logic [31:0] clock_ms     = '0;
    bit          dense_timing = 1'b0;
    int          note_on_pct  = 60;
    bit          wide_notes   = 1'b0;

    midi_note_filter_tracker dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_time_ms          (i_time_ms),
        .i_status_byte      (i_status_byte),
        .i_data_one         (i_data_one),
        .i_data_two         (i_data_two),
        .i_msg_length       (i_msg_length),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_accepted         (o_accepted),
        .o_out_note         (o_out_note),
        .o_held_count       (o_held_count),
        .o_last_note        (o_last_note),
        .o_last_velocity    (o_last_velocity),
        .o_sustain_down     (o_sustain_down),
        .o_note_events      (o_note_events),
        .o_notes_per_minute (o_notes_per_minute)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("midi_note_filter_tracker regression: fail");
            $finish;
        end
    end

    // Receiver stall: short bursts mostly, a few long holds, some long clear stretches
    always @(posedge i_clk) begin : out_stall_gen
        int pick;
        if (stall_run == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                stall_level = 1'b0;
                stall_run   = $urandom_range(100, 300);
            end else if (pick < 55) begin
                stall_level = 1'b0;
                stall_run   = $urandom_range(1, 8);
            end else if (pick < 90) begin
                stall_level = 1'b1;
                stall_run   = $urandom_range(1, 3);
            end else if (pick < 98) begin
                stall_level = 1'b1;
                stall_run   = $urandom_range(4, 12);
            end else begin
                stall_level = 1'b1;
                stall_run   = $urandom_range(20, 40);
            end
        end
        stall_run--;
        i_out_stall <= stall_level;
    end

    // Result monitor: a word moves when valid is high and stall is low
    always @(posedge i_clk) begin : result_mon
        tracker_result_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_accepted, o_out_note, o_held_count, o_last_note, o_last_velocity,
                   o_sustain_down, o_note_events, o_notes_per_minute};
            book.match_result(got);
        end
    end

    // Sender gap: mostly none or short, a few long, with runs of back-to-back words
    function automatic int pick_gap();
        int pick;
        if (quiet_words > 0) begin
            quiet_words--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            quiet_words = $urandom_range(30, 80);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one word; valid stays high into the next word when there is no gap
    task automatic push_word(input midi_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= w.action;
        i_time_ms     <= w.time_ms;
        i_status_byte <= w.status;
        i_data_one    <= w.data_one;
        i_data_two    <= w.data_two;
        i_msg_length  <= w.length;
        do @(posedge i_clk); while (o_in_stall);
        book.take_word(w);
    endtask

    task automatic send_msg(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2,
                            input logic [1:0] len, input logic [31:0] t);
        midi_word_t w;
        w = {ACT_MESSAGE, t, st, d1, d2, len};
        push_word(w);
    endtask

    task automatic send_tick(input logic [31:0] t);
        midi_word_t w;
        w = {ACT_TICK, t, 8'h00, 7'd0, 7'd0, 2'd0};
        push_word(w);
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input logic [4:0] filt, input logic signed [7:0] shift);
        write_reg(CHAN_FILTER_ADDR, {27'd0, filt});
        write_reg(TRANSPOSE_ADDR, {{24{shift[7]}}, shift});
        book.chan_filter = filt;
        book.transpose   = shift;
    endtask

    // Edge cases: zero stamp, range ends, velocity-zero release, length and status rules
    task automatic run_directed();
        send_msg({KIND_NOTE_ON, 4'h0}, 7'd60, 7'd100, 2'd3, 32'd0);
        send_msg({KIND_NOTE_ON, 4'hF}, 7'd127, 7'd127, 2'd3, 32'd10);
        send_msg({KIND_NOTE_ON, 4'h0}, 7'd0, 7'd1, 2'd3, 32'd20);
        send_msg({KIND_NOTE_ON, 4'h0}, 7'd60, 7'd0, 2'd3, 32'd30);
        send_msg({KIND_NOTE_OFF, 4'h0}, 7'd10, 7'd64, 2'd3, 32'd40);
        send_msg({KIND_NOTE_OFF, 4'hF}, 7'd127, 7'd0, 2'd3, 32'd50);
        send_msg({KIND_CTRL, 4'h0}, CC_SUSTAIN, 7'd64, 2'd3, 32'd60);
        send_msg({KIND_CTRL, 4'h0}, CC_SUSTAIN, 7'd63, 2'd3, 32'd70);
        send_msg({KIND_CTRL, 4'h3}, CC_SUSTAIN, 7'd127, 2'd3, 32'd80);
        send_msg({KIND_CTRL, 4'h0}, CC_SUSTAIN, 7'd0, 2'd2, 32'd90);
        send_msg({KIND_CTRL & 4'h7, 4'hC}, 7'd1, 7'd2, 2'd3, 32'd100);
        send_msg({KIND_NOTE_ON, 4'h0}, 7'd40, 7'd40, 2'd0, 32'd110);
        send_msg({KIND_PROG, 4'h5}, 7'd5, 7'd0, 2'd2, 32'd120);
        send_msg({KIND_PRESS, 4'h2}, 7'd9, 7'd0, 2'd1, 32'd130);
        send_msg(SYS_EX_START, 7'd1, 7'd1, 2'd3, 32'd140);
        send_msg(SYS_EX_END, 7'd1, 7'd1, 2'd3, 32'd150);
        send_msg(SYS_SONG_POS, 7'd3, 7'd4, 2'd3, 32'd160);
        send_msg(SYS_QFRAME, 7'd5, 7'd0, 2'd2, 32'd170);
        send_msg(SYS_TUNE, 7'd0, 7'd0, 2'd1, 32'd180);
        send_msg(SYS_RESET, 7'd127, 7'd127, 2'd1, 32'd190);
        send_msg({KIND_BEND, 4'h0}, 7'd0, 7'd64, 2'd3, 32'd200);
        send_tick(32'd500);
        send_tick(32'd1001);
        send_tick(32'hFFFF_FFFF);
    endtask

    // Random word: mostly well-formed traffic on the filtered channel, then broken and noise
    function automatic midi_word_t make_word();
        midi_word_t w;
        int         pick;
        int         step;
        logic [3:0] ch;
        step = $urandom_range(0, 99);
        if (dense_timing) begin
            if (step < 95) clock_ms += $urandom_range(0, 150);
            else clock_ms += $urandom_range(150, 3000);
        end else begin
            if (step < 82) clock_ms += $urandom_range(0, 400);
            else if (step < 97) clock_ms += $urandom_range(400, 3000);
            else if (step < 99) clock_ms += $urandom_range(3000, 70000);
            else clock_ms += $urandom;
        end
        w.action   = ACT_MESSAGE;
        w.time_ms  = clock_ms;
        w.length   = 2'd3;
        w.data_two = 7'($urandom);
        if (wide_notes || $urandom_range(0, 9) >= 6) w.data_one = 7'($urandom);
        else w.data_one = 7'($urandom_range(48, 72));
        if (book.chan_filter != '0 && $urandom_range(0, 9) < 8) ch = 4'(book.chan_filter - 5'd1);
        else ch = 4'($urandom);
        w.status = {KIND_NOTE_ON, ch};
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            w.action = ACT_TICK;
            w.status = 8'($urandom);
            w.length = 2'($urandom);
        end else if (pick < 62) begin
            if ($urandom_range(0, 99) < note_on_pct) begin
                if ($urandom_range(0, 9) == 0) w.data_two = '0;
            end else begin
                w.status = {KIND_NOTE_OFF, ch};
            end
        end else if (pick < 72) begin
            w.status = {KIND_CTRL, ch};
            if ($urandom_range(0, 9) < 7) w.data_one = CC_SUSTAIN;
        end else if (pick < 80) begin
            case ($urandom_range(0, 5))
                0: begin
                    w.status = {KIND_PROG, ch};
                    w.length = 2'd2;
                end
                1: begin
                    w.status = {KIND_PRESS, ch};
                    w.length = 2'($urandom_range(2, 3));
                end
                2: w.status = {KIND_POLY, ch};
                3: w.status = {KIND_BEND, ch};
                4: begin
                    w.status = {KIND_SYSTEM, 4'($urandom)};
                    w.length = 2'($urandom_range(1, 3));
                end
                default: w.status = (ch[0]) ? SYS_CLOCK : {KIND_SYSTEM, ch};
            endcase
        end else if (pick < 92) begin
            // malformed: short, status bit clear or off-filter channel
            if ($urandom_range(0, 1)) w.status = {KIND_CTRL, ch};
            if (w.status[7:4] == KIND_CTRL) w.data_one = CC_SUSTAIN;
            case ($urandom_range(0, 2))
                0: w.length = 2'($urandom_range(0, 2));
                1: w.status[7] = 1'b0;
                default: w.status[3:0] = w.status[3:0] + 4'($urandom_range(1, 15));
            endcase
        end else begin
            w = midi_word_t'({$urandom, $urandom});
        end
        return w;
    endfunction

    initial begin
        int                 filt [PHASES]  = '{0, 16, 1, 0, 10, 0, 0};
        int                 shift [PHASES] = '{0, 127, -127, -12, 5, 0, 0};
        logic [4:0]         next_filt;
        logic signed [7:0]  next_shift;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_MESSAGE;
        i_time_ms     <= '0;
        i_status_byte <= '0;
        i_data_one    <= '0;
        i_data_two    <= '0;
        i_msg_length  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apply_setting(5'd0, 8'sd0);
        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            next_filt  = 5'(filt[p]);
            next_shift = 8'(shift[p]);
            if (p == 5) begin
                next_filt  = 5'($urandom_range(0, 16));
                next_shift = 8'(int'($urandom_range(0, 254)) - 127);
            end
            apply_setting(next_filt, next_shift);
            dense_timing = (p == 1 || p == 3 || p == 5);
            wide_notes   = (p == 6);
            note_on_pct  = (p == 6) ? 95 : 60;
            // run across the 32-bit time wrap
            if (p == 3) clock_ms = 32'hFFFF_8000;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 2 && n == PHASE_WORDS / 2) drain_results();
                push_word(make_word());
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d words: %0d ticks, %0d messages accepted, %0d results checked",
                 book.words, book.ticks, book.accepts, book.checked);
        $display("peak held notes %0d, peak notes per minute %0d, over %0d register settings",
                 book.peak_held, book.peak_rate, PHASES + 1);
        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("midi_note_filter_tracker regression: pass");
        end else begin
            $display("midi_note_filter_tracker regression: fail");
        end
        $finish;
    end

endmodule
